// ===== rtl/rgbab_pkg.sv =====
// Shared types and codes for the RGBA blend unit.
`default_nettype none

package rgbab_pkg;

   // Blend factor codes; any code outside this set selects ONE.
   typedef enum logic [3:0] {
      FACT_ZERO           = 4'd0,
      FACT_ONE            = 4'd1,
      FACT_SRC_COLOR      = 4'd2,
      FACT_INV_SRC_COLOR  = 4'd3,
      FACT_DST_COLOR      = 4'd4,
      FACT_INV_DST_COLOR  = 4'd5,
      FACT_SRC_ALPHA      = 4'd6,
      FACT_INV_SRC_ALPHA  = 4'd7,
      FACT_DST_ALPHA      = 4'd8,
      FACT_INV_DST_ALPHA  = 4'd9,
      FACT_ALPHA_SATURATE = 4'd10
   } factor_code_type;

   // Register indexes of the configuration port.
   localparam logic [1:0] CSR_BLEND_ENABLE  = 2'd0;
   localparam logic [1:0] CSR_SOURCE_FACTOR = 2'd1;
   localparam logic [1:0] CSR_DEST_FACTOR   = 2'd2;

   // Reset values of the configuration registers.
   localparam logic       RST_BLEND_ENABLE  = 1'b0;
   localparam logic [3:0] RST_SOURCE_FACTOR = 4'd1;
   localparam logic [3:0] RST_DEST_FACTOR   = 4'd0;

   // Control that the top level hands to every colour lane.
   typedef struct packed {
      logic       blend_en;
      logic [3:0] src_code;
      logic [3:0] dst_code;
      logic       load_prod;
      logic       load_res;
   } lane_ctrl_type;

endpackage

`default_nettype wire

// ===== rtl/rgbab_lane.sv =====
// One colour lane: factor selection, two products, rounding divide and clamp.
`default_nettype none

module rgbab_lane #(
   parameter int CHANNEL_BITS = 8,
   parameter bit IS_ALPHA     = 1'b0
) (
   input  wire logic                      clock,
   input  wire rgbab_pkg::lane_ctrl_type  ctrl,
   input  wire logic [CHANNEL_BITS-1:0]   src_chan,
   input  wire logic [CHANNEL_BITS-1:0]   dst_chan,
   input  wire logic [CHANNEL_BITS-1:0]   src_a_chan,
   input  wire logic [CHANNEL_BITS-1:0]   dst_a_chan,
   output logic      [CHANNEL_BITS-1:0]   result
);

   localparam int CB = CHANNEL_BITS;
   localparam int SW = 2 * CB + 1;
   localparam logic [CB-1:0] MAXV = {CB{1'b1}};
   localparam logic [CB-1:0] HALF = {1'b0, {(CB-1){1'b1}}};
   // Smallest sum whose quotient would exceed the full-scale value.
   localparam logic [SW-1:0] SAT_LIM = {1'b0, MAXV, {CB{1'b0}}};

   logic [CB-1:0]   inv_dst_a;
   logic [CB-1:0]   sat_factor;
   logic [CB-1:0]   fact_s;
   logic [CB-1:0]   fact_d;
   logic [2*CB-1:0] prod_s_ff;
   logic [2*CB-1:0] prod_s_in;
   logic [2*CB-1:0] prod_d_ff;
   logic [2*CB-1:0] prod_d_in;
   logic [SW-1:0]   sum;
   logic [SW-1:0]   quo_tmp;
   logic [CB-1:0]   result_ff;
   logic [CB-1:0]   result_in;

   // Maps a factor code to a unorm factor for this lane.
   function automatic logic [CB-1:0] pick_factor(
      input logic [3:0]    code,
      input logic [CB-1:0] s,
      input logic [CB-1:0] d,
      input logic [CB-1:0] sa,
      input logic [CB-1:0] da,
      input logic [CB-1:0] sat
   );
      logic [CB-1:0] f;
      case (code)
         rgbab_pkg::FACT_ZERO:           f = '0;
         rgbab_pkg::FACT_ONE:            f = MAXV;
         rgbab_pkg::FACT_SRC_COLOR:      f = s;
         rgbab_pkg::FACT_INV_SRC_COLOR:  f = MAXV - s;
         rgbab_pkg::FACT_DST_COLOR:      f = d;
         rgbab_pkg::FACT_INV_DST_COLOR:  f = MAXV - d;
         rgbab_pkg::FACT_SRC_ALPHA:      f = sa;
         rgbab_pkg::FACT_INV_SRC_ALPHA:  f = MAXV - sa;
         rgbab_pkg::FACT_DST_ALPHA:      f = da;
         rgbab_pkg::FACT_INV_DST_ALPHA:  f = MAXV - da;
         rgbab_pkg::FACT_ALPHA_SATURATE: f = IS_ALPHA ? MAXV : sat;
         default:                        f = MAXV;
      endcase
      return f;
   endfunction

   // Factor selection. With blending off the source passes through as
   // source times one plus destination times zero, which rounds back exactly.
   always_comb begin
      inv_dst_a  = MAXV - dst_a_chan;
      sat_factor = (src_a_chan < inv_dst_a) ? src_a_chan : inv_dst_a;
      if (ctrl.blend_en) begin
         fact_s = pick_factor(ctrl.src_code, src_chan, dst_chan, src_a_chan,
                              dst_a_chan, sat_factor);
         fact_d = pick_factor(ctrl.dst_code, src_chan, dst_chan, src_a_chan,
                              dst_a_chan, sat_factor);
      end else begin
         fact_s = MAXV;
         fact_d = '0;
      end
      prod_s_in = src_chan * fact_s;
      prod_d_in = dst_chan * fact_d;
   end

   // First stage: the two products.
   always_ff @(posedge clock) begin
      if (ctrl.load_prod) begin
         prod_s_ff <= prod_s_in;
         prod_d_ff <= prod_d_in;
      end
   end

   // Rounded division by the full-scale value 2^N-1. Below the clamp limit
   // the quotient fits in N bits, where (x + (x >> N) + 1) >> N is exact.
   always_comb begin
      sum     = {1'b0, prod_s_ff} + {1'b0, prod_d_ff} + {{(CB+1){1'b0}}, HALF};
      quo_tmp = sum + (sum >> CB) + {{(SW-1){1'b0}}, 1'b1};
      if (sum >= SAT_LIM) begin
         result_in = MAXV;
      end else begin
         result_in = quo_tmp[2*CB-1:CB];
      end
   end

   // Second stage: the lane result.
   always_ff @(posedge clock) begin
      if (ctrl.load_res) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

`default_nettype wire

// ===== rtl/rgba_blend_unit.sv =====
// Top level of the RGBA blend unit: configuration, four lanes and output stage.
`default_nettype none

// The unit blends one source colour with one destination colour per item,
// channel by channel, as (src*sf + dst*df + half)/full scale, clamped, with
// the factors chosen by the source_factor and dest_factor registers; with
// blend_enable clear the source colour passes through. Four identical lanes
// (red, green, blue, alpha) work side by side, each with two multipliers.
// An item passes three register stages (product stage, divide stage, output
// stage) and presents its result from the output stage; a new item is accepted
// every cycle as long as the result side does not
// stall. Configuration writes are always taken (csr_ready is held high) and
// must only be made while no item is in flight.
module rgba_blend_unit #(
   parameter int CHANNEL_BITS = 8
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   // Item input channel.
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic [CHANNEL_BITS-1:0] req_src_red,
   input  wire logic [CHANNEL_BITS-1:0] req_src_green,
   input  wire logic [CHANNEL_BITS-1:0] req_src_blue,
   input  wire logic [CHANNEL_BITS-1:0] req_src_alpha,
   input  wire logic [CHANNEL_BITS-1:0] req_dst_red,
   input  wire logic [CHANNEL_BITS-1:0] req_dst_green,
   input  wire logic [CHANNEL_BITS-1:0] req_dst_blue,
   input  wire logic [CHANNEL_BITS-1:0] req_dst_alpha,
   // Result channel.
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic      [CHANNEL_BITS-1:0] rsp_out_red,
   output logic      [CHANNEL_BITS-1:0] rsp_out_green,
   output logic      [CHANNEL_BITS-1:0] rsp_out_blue,
   output logic      [CHANNEL_BITS-1:0] rsp_out_alpha,
   // Configuration write port.
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire logic [1:0]              csr_index,
   input  wire logic [3:0]              csr_data
);

   localparam int CB = CHANNEL_BITS;

   logic       blend_en_ff;
   logic       blend_en_in;
   logic [3:0] src_code_ff;
   logic [3:0] src_code_in;
   logic [3:0] dst_code_ff;
   logic [3:0] dst_code_in;

   logic       valid1_ff;
   logic       valid1_in;
   logic       valid2_ff;
   logic       valid2_in;
   logic       valid3_ff;
   logic       valid3_in;
   logic       ready1;
   logic       ready2;
   logic       ready3;

   rgbab_pkg::lane_ctrl_type lane_ctrl;

   logic [CB-1:0] lane_red;
   logic [CB-1:0] lane_green;
   logic [CB-1:0] lane_blue;
   logic [CB-1:0] lane_alpha;

   logic [CB-1:0] out_red_ff;
   logic [CB-1:0] out_green_ff;
   logic [CB-1:0] out_blue_ff;
   logic [CB-1:0] out_alpha_ff;

   // Configuration registers; writes to an unknown index are dropped.
   assign csr_ready = 1'b1;

   always_comb begin
      blend_en_in = blend_en_ff;
      src_code_in = src_code_ff;
      dst_code_in = dst_code_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            rgbab_pkg::CSR_BLEND_ENABLE:  blend_en_in = csr_data[0];
            rgbab_pkg::CSR_SOURCE_FACTOR: src_code_in = csr_data;
            rgbab_pkg::CSR_DEST_FACTOR:   dst_code_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blend_en_ff <= rgbab_pkg::RST_BLEND_ENABLE;
         src_code_ff <= rgbab_pkg::RST_SOURCE_FACTOR;
         dst_code_ff <= rgbab_pkg::RST_DEST_FACTOR;
      end else begin
         blend_en_ff <= blend_en_in;
         src_code_ff <= src_code_in;
         dst_code_ff <= dst_code_in;
      end
   end

   // Pipeline flow: a stage moves on when it is empty or its successor moves.
   always_comb begin
      ready3    = !valid3_ff || !rsp_stall;
      ready2    = !valid2_ff || ready3;
      ready1    = !valid1_ff || ready2;
      valid1_in = ready1 ? req_valid : valid1_ff;
      valid2_in = ready2 ? valid1_ff : valid2_ff;
      valid3_in = ready3 ? valid2_ff : valid3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
      end else begin
         valid1_ff <= valid1_in;
         valid2_ff <= valid2_in;
         valid3_ff <= valid3_in;
      end
   end

   assign req_stall = !ready1;

   always_comb begin
      lane_ctrl.blend_en  = blend_en_ff;
      lane_ctrl.src_code  = src_code_ff;
      lane_ctrl.dst_code  = dst_code_ff;
      lane_ctrl.load_prod = ready1 && req_valid;
      lane_ctrl.load_res  = ready2 && valid1_ff;
   end

   // Four colour lanes.
   rgbab_lane #(.CHANNEL_BITS(CB), .IS_ALPHA(1'b0)) u_lane_red (
      .clock      (clock),
      .ctrl       (lane_ctrl),
      .src_chan   (req_src_red),
      .dst_chan   (req_dst_red),
      .src_a_chan (req_src_alpha),
      .dst_a_chan (req_dst_alpha),
      .result     (lane_red)
   );

   rgbab_lane #(.CHANNEL_BITS(CB), .IS_ALPHA(1'b0)) u_lane_green (
      .clock      (clock),
      .ctrl       (lane_ctrl),
      .src_chan   (req_src_green),
      .dst_chan   (req_dst_green),
      .src_a_chan (req_src_alpha),
      .dst_a_chan (req_dst_alpha),
      .result     (lane_green)
   );

   rgbab_lane #(.CHANNEL_BITS(CB), .IS_ALPHA(1'b0)) u_lane_blue (
      .clock      (clock),
      .ctrl       (lane_ctrl),
      .src_chan   (req_src_blue),
      .dst_chan   (req_dst_blue),
      .src_a_chan (req_src_alpha),
      .dst_a_chan (req_dst_alpha),
      .result     (lane_blue)
   );

   rgbab_lane #(.CHANNEL_BITS(CB), .IS_ALPHA(1'b1)) u_lane_alpha (
      .clock      (clock),
      .ctrl       (lane_ctrl),
      .src_chan   (req_src_alpha),
      .dst_chan   (req_dst_alpha),
      .src_a_chan (req_src_alpha),
      .dst_a_chan (req_dst_alpha),
      .result     (lane_alpha)
   );

   // Output stage: gathers the four lane results into one item.
   always_ff @(posedge clock) begin
      if (ready3 && valid2_ff) begin
         out_red_ff   <= lane_red;
         out_green_ff <= lane_green;
         out_blue_ff  <= lane_blue;
         out_alpha_ff <= lane_alpha;
      end
   end

   assign rsp_valid     = valid3_ff;
   assign rsp_out_red   = out_red_ff;
   assign rsp_out_green = out_green_ff;
   assign rsp_out_blue  = out_blue_ff;
   assign rsp_out_alpha = out_alpha_ff;

   // The input is held off only when every stage holds an item.
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (valid1_ff && valid2_ff && valid3_ff))
      else $error("input stalled while the pipeline has an empty stage");

   // A blocked divide stage keeps its item.
   a_stage2_holds: assert property (@(posedge clock) disable iff (reset)
      (valid2_ff && !ready3) |=> valid2_ff)
      else $error("divide stage lost an item while blocked");

   // A blocked product stage keeps its item.
   a_stage1_holds: assert property (@(posedge clock) disable iff (reset)
      (valid1_ff && !ready2) |=> valid1_ff)
      else $error("product stage lost an item while blocked");

endmodule

`default_nettype wire

// ===== bench/rgba_blend_unit_tb.sv =====
// Self-checking bench for the RGBA blend unit: random fragments against a blending predictor.
`timescale 1ns / 1ps

module rgba_blend_unit_tb;

   localparam int CHANNEL_BITS = 8;
   localparam int QUIET_LIMIT = 1000;
   localparam int SETTLE_CYCLES = 6;
   localparam int RANDOM_BATCHES = 35;
   localparam int BATCH_ITEMS = 40;

   // Register index with no register behind it, and factor codes outside the defined set.
   localparam logic [1:0] CSR_SPARE_INDEX = 2'd3;
   localparam logic [3:0] FACT_SPARE_FIRST = 4'd11;
   localparam logic [3:0] FACT_SPARE_LAST = 4'd15;

   typedef logic [CHANNEL_BITS-1:0] chan_type;
   localparam chan_type CHAN_MAX = '1;

   typedef struct packed {
      chan_type red;
      chan_type green;
      chan_type blue;
      chan_type alpha;
   } colour_type;

   typedef struct packed {
      colour_type src;
      colour_type dst;
   } fragment_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic req_valid = 1'b0;
   logic req_stall;
   fragment_type drive_frag = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   chan_type rsp_out_red, rsp_out_green, rsp_out_blue, rsp_out_alpha;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = rgbab_pkg::CSR_BLEND_ENABLE;
   logic [3:0] csr_data = '0;

   // Bench copy of the blend registers.
   logic blend_on = rgbab_pkg::RST_BLEND_ENABLE;
   rgbab_pkg::factor_code_type src_code =
      rgbab_pkg::factor_code_type'(rgbab_pkg::RST_SOURCE_FACTOR);
   rgbab_pkg::factor_code_type dst_code =
      rgbab_pkg::factor_code_type'(rgbab_pkg::RST_DEST_FACTOR);

   fragment_type pending_fragments[$];
   colour_type blended_expect[$];
   fragment_type next_frag;
   colour_type want_colour;
   int outstanding = 0;
   int failures = 0;
   int quiet_cycles = 0;
   int sender_idle_pct = 21;
   int receiver_idle_pct = 51;

   rgba_blend_unit #(.CHANNEL_BITS(CHANNEL_BITS)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_src_red(drive_frag.src.red),
      .req_src_green(drive_frag.src.green),
      .req_src_blue(drive_frag.src.blue),
      .req_src_alpha(drive_frag.src.alpha),
      .req_dst_red(drive_frag.dst.red),
      .req_dst_green(drive_frag.dst.green),
      .req_dst_blue(drive_frag.dst.blue),
      .req_dst_alpha(drive_frag.dst.alpha),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_out_red(rsp_out_red),
      .rsp_out_green(rsp_out_green),
      .rsp_out_blue(rsp_out_blue),
      .rsp_out_alpha(rsp_out_alpha),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   // Blend factor for one channel; alpha saturate gives full scale on the alpha channel.
   function automatic chan_type blend_factor(rgbab_pkg::factor_code_type code,
                                             chan_type s_ch, chan_type d_ch,
                                             chan_type s_a, chan_type d_a, bit is_alpha);
      chan_type room;
      room = CHAN_MAX - d_a;
      case (code)
         rgbab_pkg::FACT_ZERO:           return '0;
         rgbab_pkg::FACT_ONE:            return CHAN_MAX;
         rgbab_pkg::FACT_SRC_COLOR:      return s_ch;
         rgbab_pkg::FACT_INV_SRC_COLOR:  return CHAN_MAX - s_ch;
         rgbab_pkg::FACT_DST_COLOR:      return d_ch;
         rgbab_pkg::FACT_INV_DST_COLOR:  return CHAN_MAX - d_ch;
         rgbab_pkg::FACT_SRC_ALPHA:      return s_a;
         rgbab_pkg::FACT_INV_SRC_ALPHA:  return CHAN_MAX - s_a;
         rgbab_pkg::FACT_DST_ALPHA:      return d_a;
         rgbab_pkg::FACT_INV_DST_ALPHA:  return CHAN_MAX - d_a;
         rgbab_pkg::FACT_ALPHA_SATURATE:
            return is_alpha ? CHAN_MAX : ((s_a < room) ? s_a : room);
         default:                        return CHAN_MAX;
      endcase
   endfunction

   // One blended channel, rounded to nearest and clamped at full scale.
   function automatic chan_type blend_channel(chan_type s_ch, chan_type d_ch, chan_type s_a,
                                              chan_type d_a, bit is_alpha);
      int unsigned total;
      int unsigned quot;
      if (!blend_on)
         return s_ch;
      total = int'(s_ch) * int'(blend_factor(src_code, s_ch, d_ch, s_a, d_a, is_alpha))
            + int'(d_ch) * int'(blend_factor(dst_code, s_ch, d_ch, s_a, d_a, is_alpha))
            + int'(CHAN_MAX) / 2;
      quot = total / int'(CHAN_MAX);
      return (quot > int'(CHAN_MAX)) ? CHAN_MAX : chan_type'(quot);
   endfunction

   function automatic colour_type blend_colour(fragment_type f);
      colour_type c;
      c.red = blend_channel(f.src.red, f.dst.red, f.src.alpha, f.dst.alpha, 1'b0);
      c.green = blend_channel(f.src.green, f.dst.green, f.src.alpha, f.dst.alpha, 1'b0);
      c.blue = blend_channel(f.src.blue, f.dst.blue, f.src.alpha, f.dst.alpha, 1'b0);
      c.alpha = blend_channel(f.src.alpha, f.dst.alpha, f.src.alpha, f.dst.alpha, 1'b1);
      return c;
   endfunction

   // Channels lean towards the extremes so that saturation and zero factors come up often.
   function automatic chan_type random_channel();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return CHAN_MAX;
         default: return chan_type'($urandom_range(0, int'(CHAN_MAX)));
      endcase
   endfunction

   function automatic colour_type random_colour();
      colour_type c;
      c.red = random_channel();
      c.green = random_channel();
      c.blue = random_channel();
      c.alpha = random_channel();
      return c;
   endfunction

   function automatic logic [3:0] random_factor();
      if ($urandom_range(0, 99) < 85)
         return 4'($urandom_range(int'(rgbab_pkg::FACT_ZERO),
                                  int'(rgbab_pkg::FACT_ALPHA_SATURATE)));
      return 4'($urandom_range(int'(FACT_SPARE_FIRST), int'(FACT_SPARE_LAST)));
   endfunction

   task automatic queue_item(colour_type s, colour_type d);
      pending_fragments.push_back('{src: s, dst: d});
      outstanding++;
   endtask

   // Waits until every queued item has produced its result, then lets the pipeline settle.
   task automatic drain();
      while (outstanding > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Holds one register write until it is taken; the caller lowers csr_valid afterwards.
   task automatic write_csr(logic [1:0] idx, logic [3:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      case (idx)
         rgbab_pkg::CSR_BLEND_ENABLE:  blend_on = data[0];
         rgbab_pkg::CSR_SOURCE_FACTOR: src_code = rgbab_pkg::factor_code_type'(data);
         rgbab_pkg::CSR_DEST_FACTOR:   dst_code = rgbab_pkg::factor_code_type'(data);
         default: ;
      endcase
   endtask

   task automatic configure(logic [3:0] enable_word, logic [3:0] src, logic [3:0] dst,
                            bit poke_spare);
      if (poke_spare)
         write_csr(CSR_SPARE_INDEX, 4'($urandom_range(0, 15)));
      write_csr(rgbab_pkg::CSR_BLEND_ENABLE, enable_word);
      write_csr(rgbab_pkg::CSR_SOURCE_FACTOR, src);
      write_csr(rgbab_pkg::CSR_DEST_FACTOR, dst);
      csr_valid <= 1'b0;
   endtask

   // Each directed setting sees black on black, white on white and one random pair.
   task automatic directed_items();
      queue_item('0, '0);
      queue_item('1, '1);
      queue_item(random_colour(), random_colour());
      drain();
   endtask

   task automatic directed_setting(logic [3:0] enable_word, logic [3:0] src, logic [3:0] dst,
                                   bit poke_spare);
      configure(enable_word, src, dst, poke_spare);
      directed_items();
   endtask

   // Driver: presents queued items, holding each one while the block stalls.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            blended_expect.push_back(blend_colour(drive_frag));
         if (!req_valid || !req_stall) begin
            if (pending_fragments.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
               next_frag = pending_fragments.pop_front();
               drive_frag <= next_frag;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic check_channel(string name, chan_type want, chan_type got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endtask

   // Monitor: compares each result item with the oldest expected colour.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (blended_expect.size() == 0) begin
            $error("result item with no expected colour: %0d %0d %0d %0d",
                   rsp_out_red, rsp_out_green, rsp_out_blue, rsp_out_alpha);
            failures++;
         end else begin
            want_colour = blended_expect.pop_front();
            check_channel("out_red", want_colour.red, rsp_out_red);
            check_channel("out_green", want_colour.green, rsp_out_green);
            check_channel("out_blue", want_colour.blue, rsp_out_blue);
            check_channel("out_alpha", want_colour.alpha, rsp_out_alpha);
            outstanding--;
         end
      end
      rsp_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
   end

   // Count cycles in which no channel moves anything.
   always @(posedge clock) begin
      if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall)
          || (csr_valid && csr_ready === 1'b1))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("Simulation FAILED");
      $finish;
   end

   // Stimulus: directed settings first, then random batches under changing back-pressure.
   initial begin
      while (reset) @(posedge clock);

      // Reset values: pass-through with no register written.
      directed_items();
      // Only bit zero of the enable word counts, so all ones switches blending on.
      directed_setting(4'hF, rgbab_pkg::FACT_ONE, rgbab_pkg::FACT_ONE, 1'b0);
      directed_setting(4'h1, rgbab_pkg::FACT_SRC_ALPHA, rgbab_pkg::FACT_INV_SRC_ALPHA, 1'b0);
      directed_setting(4'h1, rgbab_pkg::FACT_SRC_COLOR, rgbab_pkg::FACT_INV_SRC_COLOR, 1'b0);
      directed_setting(4'h1, rgbab_pkg::FACT_DST_COLOR, rgbab_pkg::FACT_INV_DST_COLOR, 1'b0);
      directed_setting(4'h1, rgbab_pkg::FACT_DST_ALPHA, rgbab_pkg::FACT_INV_DST_ALPHA, 1'b0);
      directed_setting(4'h1, rgbab_pkg::FACT_ALPHA_SATURATE, rgbab_pkg::FACT_ZERO, 1'b0);
      directed_setting(4'h1, FACT_SPARE_FIRST, FACT_SPARE_LAST, 1'b0);
      // A write to the spare index changes nothing; an even enable word turns blending off.
      directed_setting(4'hE, rgbab_pkg::FACT_ZERO, rgbab_pkg::FACT_ALPHA_SATURATE, 1'b1);

      for (int batch = 0; batch < RANDOM_BATCHES; batch++) begin
         if (batch == RANDOM_BATCHES / 3) begin
            sender_idle_pct <= 51;
            receiver_idle_pct <= 21;
         end else if (batch == 2 * RANDOM_BATCHES / 3) begin
            sender_idle_pct <= 0;
            receiver_idle_pct <= 0;
         end
         configure(4'($urandom_range(0, 15)), random_factor(), random_factor(),
                   $urandom_range(0, 3) == 0);
         for (int n = 0; n < BATCH_ITEMS; n++)
            queue_item(random_colour(), random_colour());
         drain();
      end

      if (failures == 0 && blended_expect.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/rgbab_pkg.sv
rtl/rgbab_lane.sv
rtl/rgba_blend_unit.sv
bench/rgba_blend_unit_tb.sv
